FILE: rtl/sida_pkg.sv
package sida_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned BCD_W   = NUM_DIGITS * DIGIT_W;
    localparam int unsigned CNT_W   = $clog2(VALUE_W);
    localparam int unsigned LEFT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift_digit;
    } t_dab_ctl;

    typedef struct packed {
        logic               busy;
        logic [DIGIT_W-1:0] top_digit;
    } t_dab_sts;

endpackage

FILE: rtl/sida_dabble.sv
module sida_dabble
    import sida_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dab_ctl            i_ctl,
    input  logic [VALUE_W-1:0]  i_mag,
    output t_dab_sts            o_sts
);

    logic [VALUE_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic [BCD_W-1:0]   adj;

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_ctl.load) begin
            n_bin  = i_mag;
            n_bcd  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                n_busy = 1'b0;
            end
        end else if (i_ctl.shift_digit) begin
            n_bcd = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
    end

    assign o_sts.busy      = r_busy;
    assign o_sts.top_digit = r_bcd[BCD_W-1 -: DIGIT_W];

endmodule

FILE: rtl/signed_int_to_decimal_ascii_unit.sv
// sequence: shift-add-3 conversion after the input transfer, then leading zeros are
// dropped (up to 9) and a step picks sign or digit, then one character per cycle
// (up to 11) while the receiver is ready and output stalls do not hold it
// input is taken only when the unit is idle, so a new value waits until every
// character of the last one has been issued to the output
// reset: synchronous active-low i_rst_n returns to idle and empties the output
module signed_int_to_decimal_ascii_unit
    import sida_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [6:0] character, [7] zero
    output logic        o_m_tlast
);

    t_state              r_state, n_state;
    logic                r_neg, n_neg;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;
    logic                accept;
    logic                slot_free;
    logic [VALUE_W-1:0]  mag;
    t_dab_ctl            dab_ctl;
    t_dab_sts            dab_sts;

    assign accept    = i_s_tvalid && (r_state == ST_IDLE);
    assign slot_free = !r_out_valid || i_m_tready;
    // 32-bit negate is exact as unsigned, most negative maps to 2^31
    assign mag = i_s_tdata[VALUE_W-1] ? (~i_s_tdata + VALUE_W'(1)) : i_s_tdata;

    sida_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dab_ctl),
        .i_mag   (mag),
        .o_sts   (dab_sts)
    );

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_left      = r_left;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        dab_ctl     = '0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    dab_ctl.load = 1'b1;
                    n_neg   = i_s_tdata[VALUE_W-1];
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (!dab_sts.busy) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (dab_sts.top_digit == '0 && r_left > LEFT_W'(1)) begin
                    dab_ctl.shift_digit = 1'b1;
                    n_left = r_left - LEFT_W'(1);
                end else if (r_neg) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    n_char      = CHAR_MINUS;
                    n_last      = 1'b0;
                    n_out_valid = 1'b1;
                    n_state     = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (slot_free) begin
                    n_char      = CHAR_ZERO + CHAR_W'(dab_sts.top_digit);
                    n_last      = (r_left == LEFT_W'(1));
                    n_out_valid = 1'b1;
                    dab_ctl.shift_digit = 1'b1;
                    n_left      = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_neg  <= n_neg;
        r_left <= n_left;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_char};
    assign o_m_tlast  = r_last;

endmodule
